### hdl/rrfp_pkg.sv
package rrfp_pkg;

  // Frame bytes
  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;
  localparam logic [7:0] MOVE_CODE = 8'h01;

  // Frame layout
  localparam int unsigned KEPT_BYTES = 6;
  localparam int unsigned CLOSE_POS  = 6;

  // Distance window, centimeters
  localparam logic [15:0] DIST_MAX_CM = 16'd1000;

  localparam int unsigned RRFP_DEPTH_DEF = 16;

  localparam int unsigned DIST_W = 10;

  typedef struct packed {
    logic              report_accepted;
    logic              distance_updated;
    logic              presence_flag;
    logic              movement_flag;
    logic [DIST_W-1:0] distance_cm;
  } rrfp_result_t;

endpackage

### hdl/radar_report_frame_parser.sv
// Channel | Handshake                 | Payload
// rx in   | in_valid_i / in_ready_o   | rx_byte_i[7:0]
// rpt out | out_valid_o / out_ready_i | report_accepted_o, distance_updated_o,
//         |                           | presence_flag_o, movement_flag_o,
//         |                           | distance_cm_o[9:0]
//
// One byte per cycle sustained unless a closing byte stalls: input register,
// one pass of deframe logic, result register, the last loaded by a closing byte.
// A byte that closes a frame waits in the input register only while the
// result register holds a report not yet taken; other bytes never stall.
// Reset (rst_ni low, async) clears frame bytes, position and held flags.
module radar_report_frame_parser import rrfp_pkg::*; #(
  parameter int unsigned FRAME_BUFFER_DEPTH = RRFP_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              report_accepted_o,
  output logic              distance_updated_o,
  output logic              presence_flag_o,
  output logic              movement_flag_o,
  output logic [DIST_W-1:0] distance_cm_o
);

  logic         byte_valid;
  logic [7:0]   byte_q;
  logic         close;
  logic         slot_free;
  logic         step;
  rrfp_result_t core_result;
  rrfp_result_t out_result;

  // A closing byte needs a free result slot; anything else moves on at once.
  assign step = byte_valid && (!close || slot_free);

  rrfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .byte_i  (rx_byte_i),
    .take_i  (step),
    .valid_o (byte_valid),
    .byte_o  (byte_q)
  );

  rrfp_deframer #(
    .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH)
  ) u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (byte_q),
    .close_o  (close),
    .result_o (core_result)
  );

  rrfp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && close),
    .result_i (core_result),
    .ready_i  (out_ready_i),
    .valid_o  (out_valid_o),
    .free_o   (slot_free),
    .result_o (out_result)
  );

  assign report_accepted_o  = out_result.report_accepted;
  assign distance_updated_o = out_result.distance_updated;
  assign presence_flag_o    = out_result.presence_flag;
  assign movement_flag_o    = out_result.movement_flag;
  assign distance_cm_o      = out_result.distance_cm;

endmodule

### hdl/rrfp_in_stage.sv
module rrfp_in_stage import rrfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

### hdl/rrfp_deframer.sv
module rrfp_deframer import rrfp_pkg::*; #(
  parameter int unsigned FRAME_BUFFER_DEPTH = RRFP_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output logic         close_o,
  output rrfp_result_t result_o
);

  localparam int unsigned PosW = $clog2(FRAME_BUFFER_DEPTH);
  localparam logic [PosW-1:0] ClosePos = PosW'(CLOSE_POS);
  localparam logic [PosW-1:0] KeptPos  = PosW'(KEPT_BYTES);
  localparam logic [PosW:0]   WrapPos  = (PosW+1)'(FRAME_BUFFER_DEPTH);

  logic [7:0]        frame_q [KEPT_BYTES];
  logic [PosW-1:0]   pos_q, pos_d;
  logic              presence_q, movement_q;
  logic [DIST_W-1:0] distance_q;

  logic          is_hdr, is_close, do_store;
  logic [PosW:0] pos_inc;
  logic          hdr_ok, dist_ok;
  logic [15:0]   raw_dist;
  logic          presence_d, movement_d;
  logic [DIST_W-1:0] distance_d;

  assign is_hdr   = (byte_i == HDR_BYTE);
  assign is_close = !is_hdr && (pos_q == ClosePos) && (byte_i == TAIL_BYTE) &&
                    (frame_q[5] == TAIL_BYTE);
  assign pos_inc  = {1'b0, pos_q} + (PosW+1)'(1);
  assign do_store = !is_hdr && !is_close && (pos_q != '0) && (pos_q < KeptPos);

  always_comb begin
    if (is_hdr) begin
      pos_d = (frame_q[0] == HDR_BYTE) ? PosW'(2) : PosW'(1);
    end else if (is_close) begin
      pos_d = '0;
    end else if (pos_q != '0) begin
      pos_d = (pos_inc == WrapPos) ? '0 : pos_inc[PosW-1:0];
    end else begin
      pos_d = pos_q;
    end
  end

  // Evaluation of the closed frame
  assign hdr_ok   = (frame_q[0] == HDR_BYTE) && (frame_q[1] == HDR_BYTE);
  assign raw_dist = {frame_q[4], frame_q[3]};
  assign dist_ok  = hdr_ok && (raw_dist != '0) && (raw_dist <= DIST_MAX_CM);

  assign presence_d = hdr_ok ? (frame_q[2] != '0) : presence_q;
  assign movement_d = hdr_ok ? (frame_q[2] == MOVE_CODE) : movement_q;
  assign distance_d = dist_ok ? raw_dist[DIST_W-1:0] : distance_q;

  assign close_o                   = is_close;
  assign result_o.report_accepted  = hdr_ok;
  assign result_o.distance_updated = dist_ok;
  assign result_o.presence_flag    = presence_d;
  assign result_o.movement_flag    = movement_d;
  assign result_o.distance_cm      = distance_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      presence_q <= 1'b0;
      movement_q <= 1'b0;
      distance_q <= '0;
      for (int i = 0; i < KEPT_BYTES; i++) begin
        frame_q[i] <= '0;
      end
    end else if (step_i) begin
      pos_q <= pos_d;
      if (is_hdr) begin
        if (frame_q[0] == HDR_BYTE) begin
          frame_q[1] <= byte_i;
        end else begin
          frame_q[0] <= byte_i;
        end
      end else if (do_store) begin
        frame_q[pos_q[2:0]] <= byte_i;
      end
      if (is_close) begin
        presence_q <= presence_d;
        movement_q <= movement_d;
        distance_q <= distance_d;
      end
    end
  end

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    distance_q <= DIST_MAX_CM[DIST_W-1:0])
    else $error("held distance out of range");

  a_close_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_close |=> pos_q == '0)
    else $error("position not cleared after close");

  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_hdr |=> (pos_q == PosW'(1) || pos_q == PosW'(2)))
    else $error("header did not set position");

  a_move_implies_presence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    movement_q |-> presence_q)
    else $error("movement without presence");

endmodule

### hdl/rrfp_out_stage.sv
module rrfp_out_stage import rrfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  rrfp_result_t result_i,
  input  logic         ready_i,
  output logic         valid_o,
  output logic         free_o,
  output rrfp_result_t result_o
);

  logic         valid_q;
  rrfp_result_t result_q;

  assign valid_o  = valid_q;
  assign free_o   = !valid_q || ready_i;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

### bench/rrfp_frame_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the report frame parser, keeps its own deframe
// state and compares every report against the oldest predicted one.
module rrfp_frame_checker import rrfp_pkg::*; #(
  parameter int unsigned FRAME_BUFFER_DEPTH = RRFP_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              report_accepted_i,
  input  logic              distance_updated_i,
  input  logic              presence_flag_i,
  input  logic              movement_flag_i,
  input  logic [DIST_W-1:0] distance_cm_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       reports_o,
  output int unsigned       accepted_o
);

  logic [7:0]        frame_buf [KEPT_BYTES];
  int unsigned       frame_pos;
  logic              presence_q;
  logic              movement_q;
  logic [DIST_W-1:0] distance_q;
  rrfp_result_t      report_q [$];
  rrfp_result_t      got_rpt;
  rrfp_result_t      want_rpt;

  // One received byte through the deframer; a closing tail queues a report.
  task automatic deframe_byte(input logic [7:0] b);
    rrfp_result_t rpt;
    logic [15:0]  raw;
    if (b == HDR_BYTE) begin
      if (frame_buf[0] == HDR_BYTE) begin
        frame_buf[1] = b;
        frame_pos    = 2;
      end else begin
        frame_buf[0] = b;
        frame_pos    = 1;
      end
    end else if (frame_pos == CLOSE_POS && b == TAIL_BYTE && frame_buf[5] == TAIL_BYTE) begin
      frame_pos = 0;
      rpt = '0;
      if (frame_buf[0] == HDR_BYTE && frame_buf[1] == HDR_BYTE) begin
        raw = {frame_buf[4], frame_buf[3]};
        rpt.report_accepted = 1'b1;
        presence_q = (frame_buf[2] != 8'h00);
        movement_q = (frame_buf[2] == MOVE_CODE);
        if (raw >= 16'd1 && raw <= DIST_MAX_CM) begin
          distance_q = raw[DIST_W-1:0];
          rpt.distance_updated = 1'b1;
        end
      end
      rpt.presence_flag = presence_q;
      rpt.movement_flag = movement_q;
      rpt.distance_cm   = distance_q;
      report_q.push_back(rpt);
    end else if (frame_pos > 0) begin
      // bytes past the kept window only advance the position
      if (frame_pos < KEPT_BYTES) frame_buf[frame_pos] = b;
      frame_pos++;
    end
    if (frame_pos >= FRAME_BUFFER_DEPTH) frame_pos = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEPT_BYTES; i++) frame_buf[i] = 8'h00;
      frame_pos    = 0;
      presence_q   = 1'b0;
      movement_q   = 1'b0;
      distance_q   = '0;
      report_q.delete();
      fail_count_o = 0;
      reports_o    = 0;
      accepted_o   = 0;
    end else begin
      // a byte taken this edge cannot show up as a report this edge
      if (out_valid_i && out_ready_i) begin
        got_rpt = {report_accepted_i, distance_updated_i, presence_flag_i,
                   movement_flag_i, distance_cm_i};
        reports_o++;
        if (report_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("report %0d: none expected, got acc=%0b upd=%0b pres=%0b move=%0b dist=%0d",
                     reports_o, got_rpt.report_accepted, got_rpt.distance_updated,
                     got_rpt.presence_flag, got_rpt.movement_flag, got_rpt.distance_cm);
          fail_count_o++;
        end else begin
          want_rpt = report_q.pop_front();
          if (want_rpt.report_accepted) accepted_o++;
          if (got_rpt !== want_rpt) begin
            if (fail_count_o < 10) begin
              $write("report %0d: expected acc=%0b upd=%0b pres=%0b move=%0b dist=%0d,",
                     reports_o, want_rpt.report_accepted, want_rpt.distance_updated,
                     want_rpt.presence_flag, want_rpt.movement_flag, want_rpt.distance_cm);
              $display(" got acc=%0b upd=%0b pres=%0b move=%0b dist=%0d",
                       got_rpt.report_accepted, got_rpt.distance_updated,
                       got_rpt.presence_flag, got_rpt.movement_flag, got_rpt.distance_cm);
            end
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) deframe_byte(rx_byte_i);
    end
    pending_o = report_q.size();
  end

endmodule

### bench/tb_radar_report_frame_parser.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the report frame parser. The checker instance
// beside the block does all prediction and comparison.
module tb_radar_report_frame_parser;
  import rrfp_pkg::*;

  localparam int unsigned DIRECTED_LEN     = 26;
  localparam int unsigned RAND_ITEMS       = 1540;
  localparam int unsigned QUIET_TAIL       = 250;   // last frame bytes sent with no gaps
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 8;     // margin after the last report is taken
  localparam int unsigned CYCLE_LIMIT      = 200000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              report_accepted_o;
  logic              distance_updated_o;
  logic              presence_flag_o;
  logic              movement_flag_o;
  logic [DIST_W-1:0] distance_cm_o;

  int unsigned chk_fails;
  int unsigned chk_pending;
  int unsigned chk_reports;
  int unsigned chk_accepted;

  int unsigned cycle_cnt   = 0;
  int unsigned frame_bytes = 0;   // bytes sent as part of frames
  int unsigned noise_bytes = 0;
  bit          gaps_on;
  bit          sink_hold_req;
  bit          sink_hold_done;

  logic [7:0]  directed_seq [0:DIRECTED_LEN-1];

  radar_report_frame_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .report_accepted_o  (report_accepted_o),
    .distance_updated_o (distance_updated_o),
    .presence_flag_o    (presence_flag_o),
    .movement_flag_o    (movement_flag_o),
    .distance_cm_o      (distance_cm_o)
  );

  rrfp_frame_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .report_accepted_i  (report_accepted_o),
    .distance_updated_i (distance_updated_o),
    .presence_flag_i    (presence_flag_o),
    .movement_flag_i    (movement_flag_o),
    .distance_cm_i      (distance_cm_o),
    .fail_count_o       (chk_fails),
    .pending_o          (chk_pending),
    .reports_o          (chk_reports),
    .accepted_o         (chk_accepted)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("radar_report_frame_parser regression: fail");
      $finish;
    end
  end

  // Report sink. Ready drops in random bursts; once per run it holds off
  // for a long stretch so that a pending report blocks the next closing
  // tail byte and the block deasserts in_ready_o.
  initial begin
    out_ready_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one byte request; called and returning at a falling edge. A gap
  // lowers valid before the byte is raised, never within the same step.
  task automatic send_byte(input logic [7:0] b, input bit in_frame = 1'b1);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (in_frame) frame_bytes++;
    else noise_bytes++;
  endtask

  // Random payload byte that cannot restart a frame.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0) b = TAIL_BYTE;
    if (b == HDR_BYTE) b = ~b;
    return b;
  endfunction

  // Well-formed status report: header(s), state, distance lo/hi, two tails.
  task automatic send_report_frame();
    logic [7:0]  state_b;
    logic [15:0] dist_cm;
    case ($urandom_range(0, 3))
      0:       state_b = 8'h00;
      1:       state_b = MOVE_CODE;
      2:       state_b = 8'h02;
      default: state_b = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 5))
      0:       dist_cm = 16'd0;
      1:       dist_cm = 16'd1;
      2:       dist_cm = DIST_MAX_CM;
      3:       dist_cm = DIST_MAX_CM + 16'd1;
      4:       dist_cm = 16'($urandom_range(0, 65535));
      default: dist_cm = 16'($urandom_range(1, 1000));
    endcase
    // a lone header relies on the first byte already holding a header
    send_byte(HDR_BYTE);
    if ($urandom_range(0, 3) != 0) send_byte(HDR_BYTE);
    send_byte(state_b);
    send_byte(dist_cm[7:0]);
    send_byte(dist_cm[15:8]);
    send_byte(TAIL_BYTE);
    send_byte(TAIL_BYTE);
  endtask

  // Truncated frames, bad tails, tail at the wrong place, overlong runs
  // that can wrap the position back to idle.
  task automatic send_broken_frame();
    int unsigned n;
    send_byte(HDR_BYTE);
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(body_byte());
      end
      1: begin
        repeat (3) send_byte(body_byte());
        send_byte(TAIL_BYTE);
        send_byte(TAIL_BYTE ^ 8'h01);
      end
      2: begin
        repeat (4) send_byte(body_byte());
        send_byte(TAIL_BYTE ^ 8'h80);
        send_byte(TAIL_BYTE);
        send_byte(TAIL_BYTE);
      end
      default: begin
        n = $urandom_range(10, 18);
        repeat (n) send_byte(body_byte());
      end
    endcase
  endtask

  initial begin
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    rst_ni         = 1'b0;
    gaps_on        = 1'b1;
    sink_hold_req  = 1'b0;
    sink_hold_done = 1'b0;

    // After reset the first byte is clear, so a lone header opens at one
    // and the next byte lands in the second slot: that frame is refused.
    // Then a double header with movement at the top distance, a presence
    // frame one past the distance window, and an idle state at distance one.
    directed_seq = '{HDR_BYTE, MOVE_CODE, 8'h00, 8'h00, 8'h00, TAIL_BYTE, TAIL_BYTE,
                     HDR_BYTE, HDR_BYTE, MOVE_CODE, 8'hE8, 8'h03, TAIL_BYTE, TAIL_BYTE,
                     HDR_BYTE, 8'hFF, 8'hE9, 8'h03, TAIL_BYTE, TAIL_BYTE,
                     HDR_BYTE, 8'h00, 8'h01, 8'h00, TAIL_BYTE, TAIL_BYTE};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIRECTED_LEN; i++) send_byte(directed_seq[i]);
    // third and fourth directed frames: the header alone jumps to the state slot
    // since the first header slot already holds a header

    while (frame_bytes < DIRECTED_LEN + RAND_ITEMS) begin
      if (!sink_hold_done && frame_bytes >= RAND_ITEMS / 3) begin
        sink_hold_req  = 1'b1;
        sink_hold_done = 1'b1;
      end
      if (frame_bytes >= DIRECTED_LEN + RAND_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2: send_broken_frame();
        3, 4: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        default: send_report_frame();
      endcase
    end
    in_valid_i <= 1'b0;

    while (chk_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d frame bytes and %0d noise bytes, one %0d-cycle sink stall.",
             frame_bytes, noise_bytes, SINK_HOLD_CYCLES);
    $display("Checked %0d reports, %0d of them accepted, %0d mismatches.",
             chk_reports, chk_accepted, chk_fails);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("radar_report_frame_parser regression: pass");
    end else begin
      $display("radar_report_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
